// ===== rtl/cscv_pkg.sv =====
`timescale 1ns / 1ps
package cscv_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int LEN_W = 46;
  localparam int ANG_W = 36;

  localparam logic [2:0] REQ_PASS    = 3'd0;
  localparam logic [2:0] REQ_CYL2CAR = 3'd1;
  localparam logic [2:0] REQ_SPH2CAR = 3'd2;
  localparam logic [2:0] REQ_CAR2SPH = 3'd3;
  localparam logic [2:0] REQ_CAR2CYL = 3'd4;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam longint unsigned KINF_Q32 = 64'd2608131496;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic vld;
    logic rot;
  } pass_ctl_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 36'sd843314857;
      1: v = 36'sd497837829;
      2: v = 36'sd263043837;
      3: v = 36'sd133525159;
      4: v = 36'sd67021687;
      5: v = 36'sd33543516;
      6: v = 36'sd16775851;
      7: v = 36'sd8388437;
      8: v = 36'sd4194283;
      9: v = 36'sd2097149;
      10: v = 36'sd1048576;
      default: v = (i <= 30) ? ANG_W'(64'sd1 <<< (30 - i)) : '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/cscv_pass.sv =====
`timescale 1ns / 1ps
module cscv_pass #(
  parameter int NST = 24,
  parameter logic [31:0] KINV = 32'd2608131496,
  parameter int SIDE_W = 99
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cscv_pkg::pass_ctl_t                 in_ctl,
  input  logic signed [cscv_pkg::LEN_W-1:0]   x_i,
  input  logic signed [cscv_pkg::LEN_W-1:0]   y_i,
  input  logic signed [cscv_pkg::ANG_W-1:0]   a_i,
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                vld_o,
  output logic signed [cscv_pkg::LEN_W-1:0]   u_o,
  output logic signed [cscv_pkg::LEN_W-1:0]   v_o,
  output logic [SIDE_W-1:0]                   side_o
);

  localparam int LW = cscv_pkg::LEN_W;
  localparam int AW = cscv_pkg::ANG_W;
  localparam int HW = LW - 16;

  logic signed [LW-1:0] x_r [0:NST];
  logic signed [LW-1:0] y_r [0:NST];
  logic signed [AW-1:0] a_r [0:NST];
  logic                 vld_r [0:NST];
  logic                 rot_r [0:NST];
  logic                 zero_r [0:NST];
  logic [SIDE_W-1:0]    side_r [0:NST];

  logic signed [LW-1:0] x_nxt, y_nxt;
  logic signed [AW-1:0] a_nxt;
  logic                 zero_nxt;

  // fold rotation angle into +-pi/2; seed vectoring for the left half plane
  always_comb begin
    x_nxt = x_i;
    y_nxt = y_i;
    a_nxt = a_i;
    zero_nxt = 1'b0;
    if (in_ctl.rot) begin
      if (a_i > cscv_pkg::HALF_PI_Q30) begin
        a_nxt = a_i - cscv_pkg::PI_Q30;
        x_nxt = -x_i;
        y_nxt = -y_i;
      end else if (a_i < -cscv_pkg::HALF_PI_Q30) begin
        a_nxt = a_i + cscv_pkg::PI_Q30;
        x_nxt = -x_i;
        y_nxt = -y_i;
      end
    end else begin
      zero_nxt = (x_i == '0) && (y_i == '0);
      a_nxt = '0;
      if (x_i < 0) begin
        a_nxt = (y_i >= 0) ? cscv_pkg::PI_Q30 : -cscv_pkg::PI_Q30;
        x_nxt = -x_i;
        y_nxt = -y_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_ctl.vld;
    end
    x_r[0] <= x_nxt;
    y_r[0] <= y_nxt;
    a_r[0] <= a_nxt;
    rot_r[0] <= in_ctl.rot;
    zero_r[0] <= zero_nxt;
    side_r[0] <= side_i;
  end

  for (genvar k = 0; k < NST; k++) begin : g_iter
    logic cw;
    logic signed [LW-1:0] dx, dy;
    assign cw = rot_r[k] ? (a_r[k] < 0) : (y_r[k] >= 0);
    assign dx = y_r[k] >>> k;
    assign dy = x_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      if (cw) begin
        x_r[k+1] <= x_r[k] + dx;
        y_r[k+1] <= y_r[k] - dy;
        a_r[k+1] <= a_r[k] + cscv_pkg::atan_q30(k);
      end else begin
        x_r[k+1] <= x_r[k] - dx;
        y_r[k+1] <= y_r[k] + dy;
        a_r[k+1] <= a_r[k] - cscv_pkg::atan_q30(k);
      end
      rot_r[k+1] <= rot_r[k];
      zero_r[k+1] <= zero_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  // gain correction: magnitude, two partial products, round and restore sign
  logic            g1_vld_r, g2_vld_r, g3_vld_r;
  logic            g1_rot_r, g2_rot_r;
  logic            g1_xneg_r, g1_yneg_r, g2_xneg_r, g2_yneg_r;
  logic [LW-1:0]   g1_xm_r, g1_ym_r;
  logic signed [LW-1:0] g1_ang_r, g2_ang_r;
  logic [HW+31:0]  g2_xhi_r, g2_yhi_r;
  logic [47:0]     g2_xlo_r, g2_ylo_r;
  logic [SIDE_W-1:0] g1_side_r, g2_side_r, g3_side_r;
  logic signed [LW-1:0] g3_u_r, g3_v_r;
  logic [HW+32:0]  xsum, ysum;
  logic [LW-1:0]   xmag, ymag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
      g3_vld_r <= 1'b0;
    end else begin
      g1_vld_r <= vld_r[NST];
      g2_vld_r <= g1_vld_r;
      g3_vld_r <= g2_vld_r;
    end
    g1_xneg_r <= x_r[NST] < 0;
    g1_yneg_r <= y_r[NST] < 0;
    g1_xm_r <= (x_r[NST] < 0) ? LW'(-x_r[NST]) : LW'(x_r[NST]);
    g1_ym_r <= (y_r[NST] < 0) ? LW'(-y_r[NST]) : LW'(y_r[NST]);
    g1_ang_r <= zero_r[NST] ? '0 : LW'(a_r[NST]);
    g1_rot_r <= rot_r[NST];
    g1_side_r <= side_r[NST];

    g2_xhi_r <= g1_xm_r[LW-1:16] * KINV;
    g2_yhi_r <= g1_ym_r[LW-1:16] * KINV;
    g2_xlo_r <= g1_xm_r[15:0] * KINV;
    g2_ylo_r <= g1_ym_r[15:0] * KINV;
    g2_xneg_r <= g1_xneg_r;
    g2_yneg_r <= g1_yneg_r;
    g2_ang_r <= g1_ang_r;
    g2_rot_r <= g1_rot_r;
    g2_side_r <= g1_side_r;

    g3_u_r <= g2_xneg_r ? -$signed(xmag) : $signed(xmag);
    if (g2_rot_r) begin
      g3_v_r <= g2_yneg_r ? -$signed(ymag) : $signed(ymag);
    end else begin
      g3_v_r <= g2_ang_r;
    end
    g3_side_r <= g2_side_r;
  end

  always_comb begin
    xsum = (HW+33)'(g2_xhi_r) + (HW+33)'(g2_xlo_r[47:16]) + (HW+33)'(17'h08000);
    ysum = (HW+33)'(g2_yhi_r) + (HW+33)'(g2_ylo_r[47:16]) + (HW+33)'(17'h08000);
    xmag = xsum[LW+15:16];
    ymag = ysum[LW+15:16];
  end

  assign vld_o  = g3_vld_r;
  assign u_o    = g3_u_r;
  assign v_o    = g3_v_r;
  assign side_o = g3_side_r;

endmodule

// ===== rtl/coordinate_system_converter.sv =====
`timescale 1ns / 1ps
// channel | ports                       | direction | handshake
// input   | start, busy, in_item        | in        | start && !busy
// result  | out_valid, out_item         | out       | out_valid, one cycle
//
// One item enters per cycle; busy is never raised.
// The pipeline is an input register, two chained CORDIC passes (a seed register,
// N stages, N = clamped CORDIC_STAGES, and a three-stage gain multiply each) and
// an output register.
// Synchronous active-low reset clears only the valid bits.
// The receiver cannot stall; results leave on a fixed schedule.
module coordinate_system_converter #(
  parameter int CORDIC_STAGES = cscv_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cscv_pkg::in_t  in_item,
  output logic           out_valid,
  output cscv_pkg::out_t out_item
);

  localparam int NST = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);
  localparam longint unsigned KINV_L =
      cscv_pkg::KINF_Q32 + ((cscv_pkg::KINF_Q32 >> (2 * NST - 1)) / 3);
  localparam logic [31:0] KINV = KINV_L[31:0];
  localparam int LW = cscv_pkg::LEN_W;
  localparam int AW = cscv_pkg::ANG_W;
  localparam int S1_W = $bits(cscv_pkg::in_t);
  localparam int S2_W = S1_W + 2 * LW;

  function automatic logic [32:0] len_sat(input logic signed [LW-1:0] v);
    logic signed [LW-1:0] t;
    logic [32:0] res;
    t = (v + LW'(128)) >>> 8;
    if (t > LW'(64'sd2147483647)) begin
      res = {1'b1, 32'h7fffffff};
    end else if (t < -LW'(64'sd2147483648)) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, t[31:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] ang_rnd(input logic signed [LW-1:0] v);
    logic signed [LW-1:0] t;
    t = (v + LW'(1)) >>> 1;
    return t[31:0];
  endfunction

  logic          in_vld_r;
  cscv_pkg::in_t in_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    in_r <= in_item;
  end

  // first pass: rotate (r,0) by the first angle, or vector (x,y)
  cscv_pkg::pass_ctl_t  p1_ctl;
  logic signed [LW-1:0] p1_x, p1_y;
  logic signed [AW-1:0] p1_a;

  always_comb begin
    p1_ctl.vld = in_vld_r;
    p1_ctl.rot = !(in_r.req_type == cscv_pkg::REQ_CAR2SPH ||
                   in_r.req_type == cscv_pkg::REQ_CAR2CYL);
    p1_x = LW'($signed({in_r.coord_a, 8'h00}));
    p1_y = p1_ctl.rot ? '0 : LW'($signed({in_r.coord_b, 8'h00}));
    p1_a = AW'($signed({in_r.coord_b, 1'b0}));
  end

  logic                 q1_vld;
  logic signed [LW-1:0] q1_u, q1_v;
  logic [S1_W-1:0]      q1_side;

  cscv_pass #(.NST(NST), .KINV(KINV), .SIDE_W(S1_W)) u_pass1 (
    .clk, .rst_n,
    .in_ctl(p1_ctl), .x_i(p1_x), .y_i(p1_y), .a_i(p1_a), .side_i(in_r),
    .vld_o(q1_vld), .u_o(q1_u), .v_o(q1_v), .side_o(q1_side)
  );

  // second pass: rotate (rho,0) by spherical phi, or vector (z,R)
  cscv_pkg::in_t        q1_item;
  cscv_pkg::pass_ctl_t  p2_ctl;
  logic signed [LW-1:0] p2_x, p2_y;
  logic signed [AW-1:0] p2_a;

  always_comb begin
    q1_item = cscv_pkg::in_t'(q1_side);
    p2_ctl.vld = q1_vld;
    p2_ctl.rot = 1'b1;
    p2_x = '0;
    p2_y = '0;
    p2_a = '0;
    case (q1_item.req_type)
      cscv_pkg::REQ_SPH2CAR: begin
        p2_x = q1_v;
        p2_a = AW'($signed({q1_item.coord_c, 1'b0}));
      end
      cscv_pkg::REQ_CAR2SPH: begin
        p2_ctl.rot = 1'b0;
        p2_x = LW'($signed({q1_item.coord_c, 8'h00}));
        p2_y = q1_u;
      end
      default: begin
        p2_ctl.rot = 1'b1;
      end
    endcase
  end

  logic                 q2_vld;
  logic signed [LW-1:0] q2_u, q2_v;
  logic [S2_W-1:0]      q2_side;

  cscv_pass #(.NST(NST), .KINV(KINV), .SIDE_W(S2_W)) u_pass2 (
    .clk, .rst_n,
    .in_ctl(p2_ctl), .x_i(p2_x), .y_i(p2_y), .a_i(p2_a),
    .side_i({q1_side, q1_u, q1_v}),
    .vld_o(q2_vld), .u_o(q2_u), .v_o(q2_v), .side_o(q2_side)
  );

  // pick the result fields per request and round into the port formats
  cscv_pkg::in_t        q2_item;
  logic signed [LW-1:0] q2_u1, q2_v1;
  logic [32:0]          sa, sb, sc;
  cscv_pkg::out_t       out_nxt;
  logic                 out_vld_r;
  cscv_pkg::out_t       out_r;

  always_comb begin
    q2_item = cscv_pkg::in_t'(q2_side[S2_W-1 -: S1_W]);
    q2_u1 = q2_side[2*LW-1:LW];
    q2_v1 = q2_side[LW-1:0];
    sa = '0;
    sb = '0;
    sc = '0;
    out_nxt.out_a = q2_item.coord_a;
    out_nxt.out_b = q2_item.coord_b;
    out_nxt.out_c = q2_item.coord_c;
    out_nxt.saturated = 1'b0;
    case (q2_item.req_type)
      cscv_pkg::REQ_CYL2CAR: begin
        sa = len_sat(q2_u1);
        sb = len_sat(q2_v1);
        out_nxt.out_a = sa[31:0];
        out_nxt.out_b = sb[31:0];
        out_nxt.saturated = sa[32] | sb[32];
      end
      cscv_pkg::REQ_SPH2CAR: begin
        sa = len_sat(q2_u);
        sb = len_sat(q2_v);
        sc = len_sat(q2_u1);
        out_nxt.out_a = sa[31:0];
        out_nxt.out_b = sb[31:0];
        out_nxt.out_c = sc[31:0];
        out_nxt.saturated = sa[32] | sb[32] | sc[32];
      end
      cscv_pkg::REQ_CAR2SPH: begin
        sa = len_sat(q2_u);
        out_nxt.out_a = sa[31:0];
        out_nxt.out_b = ang_rnd(q2_v);
        out_nxt.out_c = ang_rnd(q2_v1);
        out_nxt.saturated = sa[32];
      end
      cscv_pkg::REQ_CAR2CYL: begin
        sa = len_sat(q2_u1);
        out_nxt.out_a = sa[31:0];
        out_nxt.out_b = ang_rnd(q2_v1);
        out_nxt.saturated = sa[32];
      end
      default: begin
        out_nxt.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= q2_vld;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/cscv_chk.sv =====
`timescale 1ns / 1ps
module cscv_chk #(
  parameter int CORDIC_STAGES = cscv_pkg::CORDIC_STAGES_DEF
) (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input cscv_pkg::out_t out_item
);

  localparam int NST = (CORDIC_STAGES < 8) ? 8 : ((CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES);
  localparam int LAT = 2 * NST + 10;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(start, LAT))
    else $error("result without item accepted at fixed latency");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && out_item.saturated) |->
        (out_item.out_a == 32'sh7fffffff || out_item.out_a == 32'sh80000000 ||
         out_item.out_b == 32'sh7fffffff || out_item.out_b == 32'sh80000000 ||
         out_item.out_c == 32'sh7fffffff || out_item.out_c == 32'sh80000000))
    else $error("saturated flag without a clamped field");

endmodule

bind coordinate_system_converter cscv_chk #(.CORDIC_STAGES(CORDIC_STAGES)) u_cscv_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int NST = (cscv_pkg::CORDIC_STAGES_DEF < 8) ? 8 :
                       (cscv_pkg::CORDIC_STAGES_DEF > 32) ? 32 :
                       cscv_pkg::CORDIC_STAGES_DEF;
  localparam longint unsigned KINV =
      cscv_pkg::KINF_Q32 + ((cscv_pkg::KINF_Q32 >> (2 * NST - 1)) / 3);
  localparam longint PI_L = 64'sd3373259426;
  localparam longint HPI_L = 64'sd1686629713;
  localparam int N_RANDOM = 700;
  localparam int LIMIT = 200000;
  localparam int DRAIN = 2 * NST + 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cscv_pkg::in_t in_item = '0;
  logic out_valid;
  cscv_pkg::out_t out_item;

  cscv_pkg::out_t pending_points[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  coordinate_system_converter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic longint atan_step(int i);
    longint head[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return head[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint gain_scale(longint v);
    bit neg;
    longint unsigned m, hi, lo, r;
    neg = v < 0;
    m = neg ? -v : v;
    hi = (m >> 16) * KINV;
    lo = (m & 64'hFFFF) * KINV;
    r = (hi + (lo >> 16) + 64'h8000) >> 16;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic void cordic_rotate(longint x, longint y, longint a,
                                        output longint ox, output longint oy);
    longint dx, dy;
    if (a > HPI_L) begin
      a -= PI_L; x = -x; y = -y;
    end else if (a < -HPI_L) begin
      a += PI_L; x = -x; y = -y;
    end
    for (int i = 0; i < NST; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= atan_step(i);
      end else begin
        x += dx; y -= dy; a += atan_step(i);
      end
    end
    ox = gain_scale(x);
    oy = gain_scale(y);
  endfunction

  function automatic longint cordic_vector(longint x, longint y, output longint ang);
    longint a, dx, dy;
    a = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      return 0;
    end
    if (x < 0) begin
      a = (y >= 0) ? PI_L : -PI_L;
      x = -x; y = -y;
    end
    for (int i = 0; i < NST; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; a += atan_step(i);
      end else begin
        x -= dx; y += dy; a -= atan_step(i);
      end
    end
    ang = a;
    return gain_scale(x);
  endfunction

  function automatic logic [31:0] clamp_len(longint v, inout logic sat);
    longint t;
    t = (v + 128) >>> 8;
    if (t > 64'sd2147483647) begin
      t = 64'sd2147483647; sat = 1'b1;
    end
    if (t < -64'sd2147483648) begin
      t = -64'sd2147483648; sat = 1'b1;
    end
    return t[31:0];
  endfunction

  function automatic logic [31:0] angle_q29(longint v);
    longint t;
    t = (v + 1) >>> 1;
    return t[31:0];
  endfunction

  function automatic cscv_pkg::out_t convert_point(cscv_pkg::in_t it);
    cscv_pkg::out_t o;
    longint a, b, c, x, y, z, rho, big_r, r, phi, th;
    logic sat;
    a = longint'(it.coord_a);
    b = longint'(it.coord_b);
    c = longint'(it.coord_c);
    sat = 1'b0;
    o = '0;
    case (it.req_type)
      cscv_pkg::REQ_CYL2CAR: begin
        cordic_rotate(a * 256, 0, b * 2, x, y);
        o.out_a = clamp_len(x, sat);
        o.out_b = clamp_len(y, sat);
        o.out_c = it.coord_c;
      end
      cscv_pkg::REQ_SPH2CAR: begin
        cordic_rotate(a * 256, 0, b * 2, z, rho);
        cordic_rotate(rho, 0, c * 2, x, y);
        o.out_a = clamp_len(x, sat);
        o.out_b = clamp_len(y, sat);
        o.out_c = clamp_len(z, sat);
      end
      cscv_pkg::REQ_CAR2SPH: begin
        if (a != 0 || b != 0 || c != 0) begin
          big_r = cordic_vector(a * 256, b * 256, phi);
          r = cordic_vector(c * 256, big_r, th);
          o.out_a = clamp_len(r, sat);
          o.out_b = angle_q29(th);
          o.out_c = angle_q29(phi);
        end
      end
      cscv_pkg::REQ_CAR2CYL: begin
        big_r = cordic_vector(a * 256, b * 256, phi);
        o.out_a = clamp_len(big_r, sat);
        o.out_b = angle_q29(phi);
        o.out_c = it.coord_c;
      end
      default: begin
        o.out_a = it.coord_a;
        o.out_b = it.coord_b;
        o.out_c = it.coord_c;
      end
    endcase
    o.saturated = sat;
    return o;
  endfunction

  // log accepted items and check results as they leave
  always @(posedge clk) begin
    cscv_pkg::out_t exp_pt;
    cycles <= cycles + 1;
    if (rst_n && start && !busy)
      pending_points.push_back(convert_point(in_item));
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_item);
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_item !== exp_pt) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp a=%h b=%h c=%h s=%b got a=%h b=%h c=%h s=%b",
                     exp_pt.out_a, exp_pt.out_b, exp_pt.out_c, exp_pt.saturated,
                     out_item.out_a, out_item.out_b, out_item.out_c,
                     out_item.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("coordinate_system_converter test failed");
      $finish;
    end
  end

  // enter at a falling edge, leave at the falling edge after acceptance
  task automatic send_point(cscv_pkg::in_t it);
    while (idle_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      2: return 32'($signed($urandom_range(3373259426)) - 1686629713);
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  typedef struct {
    cscv_pkg::in_t  stim;
    bit             typed;
    cscv_pkg::out_t result;
  } vector_row_t;

  vector_row_t directed[] = '{
    '{'{cscv_pkg::REQ_PASS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0}},
    '{'{cscv_pkg::REQ_PASS, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1,
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
    '{'{3'd5, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F}, 1,
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1'b0}},
    '{'{3'd6, 32'hFFFF_FFFF, 32'h0, 32'h5555_5555}, 1,
      '{32'hFFFF_FFFF, 32'h0, 32'h5555_5555, 1'b0}},
    '{'{3'd7, 32'hAAAA_AAAA, 32'h1, 32'h8000_0000}, 1,
      '{32'hAAAA_AAAA, 32'h1, 32'h8000_0000, 1'b0}},
    '{'{cscv_pkg::REQ_CAR2SPH, 32'h0, 32'h0, 32'h0}, 1,
      '{32'h0, 32'h0, 32'h0, 1'b0}},
    '{'{cscv_pkg::REQ_CAR2CYL, 32'h0, 32'h0, 32'h1234}, 1,
      '{32'h0, 32'h0, 32'h1234, 1'b0}},
    '{'{cscv_pkg::REQ_CYL2CAR, 32'h0001_0000, 32'h0, 32'h7}, 0, '0},
    '{'{cscv_pkg::REQ_CYL2CAR, 32'hFFFF_0000, 32'h3243_F6A9, 32'h0}, 0, '0},
    '{'{cscv_pkg::REQ_CYL2CAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 0, '0},
    '{'{cscv_pkg::REQ_CYL2CAR, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 0, '0},
    '{'{cscv_pkg::REQ_SPH2CAR, 32'h0002_0000, 32'h1921_FB54, 32'h6487_ED51}, 0, '0},
    '{'{cscv_pkg::REQ_SPH2CAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, '0},
    '{'{cscv_pkg::REQ_SPH2CAR, 32'hFFFE_0000, 32'h0, 32'h9B78_12AF}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2SPH, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2SPH, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2SPH, 32'hFFFF_0000, 32'h0, 32'h0}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2SPH, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2SPH, 32'h0, 32'h0, 32'hFFFF_0000}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2CYL, 32'hFFFF_0000, 32'h0, 32'h0}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2CYL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 0, '0},
    '{'{cscv_pkg::REQ_CAR2CYL, 32'h0, 32'hFFFF_FFFF, 32'h1}, 0, '0}
  };

  initial begin
    cscv_pkg::in_t it;
    int drain;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].typed && convert_point(directed[i].stim) !== directed[i].result) begin
        errors++;
        if (errors <= 10) $display("directed row %0d disagrees with hand value", i);
      end
      send_point(directed[i].stim);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      idle_on = !(n >= 300 && n < 400);
      // hold off once until the pipeline has emptied
      if (n == 500) begin
        start <= 1'b0;
        while (pending_points.size() != 0) @(negedge clk);
      end
      it.req_type = ($urandom_range(9) == 0) ? 3'($urandom_range(7))
                                             : 3'($urandom_range(4));
      it.coord_a = pick_coord();
      it.coord_b = pick_coord();
      it.coord_c = pick_coord();
      send_point(it);
    end
    start <= 1'b0;

    while (pending_points.size() != 0) @(negedge clk);
    drain = 0;
    while (drain < DRAIN) begin
      @(negedge clk);
      drain++;
    end

    if (errors == 0 && pending_points.size() == 0)
      $display("coordinate_system_converter test passed");
    else
      $display("coordinate_system_converter test failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/cscv_pkg.sv
rtl/cscv_pass.sv
rtl/coordinate_system_converter.sv
rtl/cscv_chk.sv
tb/tb.sv
